### rtl/lidar_frame_proximity_indicator_top_macros.svh
// ----------------------------------------------------------------------------
// lidar frame proximity indicator assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_PROXIMITY_INDICATOR_TOP_MACROS_SVH
`define LIDAR_FRAME_PROXIMITY_INDICATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, quiet while reset is high
`define LFPI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// clocked check, also active during reset
`define LFPI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LFPI_ASSERT(label, prop, msg)
`define LFPI_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### rtl/lfpi_pkg.sv
// ----------------------------------------------------------------------------
// lfpi_pkg
// types and constants shared by the lidar frame proximity indicator
// ----------------------------------------------------------------------------
`default_nettype none

package lfpi_pkg;

   localparam logic [7:0]  HEADER_BYTE = 8'h59;

   localparam logic        OP_BYTE = 1'b0;
   localparam logic        OP_TICK = 1'b1;

   localparam logic [15:0] FAR_LIMIT_RESET     = 16'd200;
   localparam logic [15:0] CAUTION_LIMIT_RESET = 16'd100;
   localparam logic [15:0] STOP_LIMIT_RESET    = 16'd60;
   localparam logic [15:0] BLINK_PERIOD_RESET  = 16'd3267;

   localparam int ADDR_W = 4;

   typedef enum logic [1:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_LOW,
      PH_HIGH
   } phase_type;

   typedef enum logic [1:0] {
      ZONE_FAR,
      ZONE_CAUTION,
      ZONE_NEAR,
      ZONE_STOP
   } zone_type;

   typedef enum logic [1:0] {
      REG_FAR_LIMIT,
      REG_CAUTION_LIMIT,
      REG_STOP_LIMIT,
      REG_BLINK_HALF_PERIOD
   } reg_index_type;

   typedef struct packed {
      logic [15:0] far_limit;
      logic [15:0] caution_limit;
      logic [15:0] stop_limit;
      logic [15:0] blink_half_period;
   } cfg_type;

   typedef struct packed {
      logic        frame_done;
      logic [15:0] distance;
      logic        blink_phase;
   } frame_type;

endpackage

`default_nettype wire

### rtl/lfpi_csr.sv
// ----------------------------------------------------------------------------
// lfpi_csr
// apb-style register bank for the zone limits and blink period
// ----------------------------------------------------------------------------
`default_nettype none

module lfpi_csr (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [lfpi_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic      [31:0]              prdata,
   output lfpi_pkg::cfg_type             cfg
);

   lfpi_pkg::cfg_type     cfg_ff;
   lfpi_pkg::cfg_type     cfg_in;
   lfpi_pkg::reg_index_type reg_index;
   logic                  write_en;

   assign reg_index = lfpi_pkg::reg_index_type'(paddr[3:2]);
   assign write_en  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            lfpi_pkg::REG_FAR_LIMIT:         cfg_in.far_limit         = pwdata[15:0];
            lfpi_pkg::REG_CAUTION_LIMIT:     cfg_in.caution_limit     = pwdata[15:0];
            lfpi_pkg::REG_STOP_LIMIT:        cfg_in.stop_limit        = pwdata[15:0];
            lfpi_pkg::REG_BLINK_HALF_PERIOD: cfg_in.blink_half_period = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.far_limit         <= lfpi_pkg::FAR_LIMIT_RESET;
         cfg_ff.caution_limit     <= lfpi_pkg::CAUTION_LIMIT_RESET;
         cfg_ff.stop_limit        <= lfpi_pkg::STOP_LIMIT_RESET;
         cfg_ff.blink_half_period <= lfpi_pkg::BLINK_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         lfpi_pkg::REG_FAR_LIMIT:         prdata = {16'd0, cfg_ff.far_limit};
         lfpi_pkg::REG_CAUTION_LIMIT:     prdata = {16'd0, cfg_ff.caution_limit};
         lfpi_pkg::REG_STOP_LIMIT:        prdata = {16'd0, cfg_ff.stop_limit};
         lfpi_pkg::REG_BLINK_HALF_PERIOD: prdata = {16'd0, cfg_ff.blink_half_period};
         default:                         prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/lfpi_parser.sv
// ----------------------------------------------------------------------------
// lfpi_parser
// header hunt, distance assembly and blink tick counter
// ----------------------------------------------------------------------------
`default_nettype none
`include "lidar_frame_proximity_indicator_top_macros.svh"

module lfpi_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        op,
   input  wire logic [7:0]  byte_value,
   input  wire logic [15:0] blink_half_period,
   output lfpi_pkg::frame_type frame
);

   lfpi_pkg::phase_type phase_ff;
   lfpi_pkg::phase_type phase_in;
   logic [7:0]          low_ff;
   logic [7:0]          low_in;
   logic [15:0]         tick_ff;
   logic [15:0]         tick_in;
   logic                blink_ff;
   logic                blink_in;
   logic [15:0]         tick_next;

   assign tick_next = tick_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lfpi_pkg::PH_HUNT1;
         low_ff   <= 8'd0;
         tick_ff  <= 16'd0;
         blink_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         low_ff   <= low_in;
         tick_ff  <= tick_in;
         blink_ff <= blink_in;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      low_in            = low_ff;
      tick_in           = tick_ff;
      blink_in          = blink_ff;
      frame.frame_done  = 1'b0;
      frame.distance    = {byte_value, low_ff};
      frame.blink_phase = blink_ff;
      if (step) begin
         if (op == lfpi_pkg::OP_TICK) begin
            // zero period counts as one: next >= 0 always toggles
            if (tick_next >= blink_half_period) begin
               tick_in  = 16'd0;
               blink_in = ~blink_ff;
            end else begin
               tick_in = tick_next;
            end
         end else begin
            case (phase_ff)
               lfpi_pkg::PH_HUNT1: begin
                  phase_in = (byte_value == lfpi_pkg::HEADER_BYTE) ?
                             lfpi_pkg::PH_HUNT2 : lfpi_pkg::PH_HUNT1;
               end
               lfpi_pkg::PH_HUNT2: begin
                  phase_in = (byte_value == lfpi_pkg::HEADER_BYTE) ?
                             lfpi_pkg::PH_LOW : lfpi_pkg::PH_HUNT1;
               end
               lfpi_pkg::PH_LOW: begin
                  low_in   = byte_value;
                  phase_in = lfpi_pkg::PH_HIGH;
               end
               lfpi_pkg::PH_HIGH: begin
                  frame.frame_done = 1'b1;
                  phase_in         = lfpi_pkg::PH_HUNT1;
               end
               default: phase_in = lfpi_pkg::PH_HUNT1;
            endcase
         end
      end
   end

   // a finished frame always restarts the header hunt
   `LFPI_ASSERT(a_frame_restarts_hunt, frame.frame_done |=> phase_ff == lfpi_pkg::PH_HUNT1, "frame did not restart hunt")

endmodule

`default_nettype wire

### rtl/lfpi_classify.sv
// ----------------------------------------------------------------------------
// lfpi_classify
// zone decision and indicator drive from the assembled distance
// ----------------------------------------------------------------------------
`default_nettype none

module lfpi_classify (
   input  wire logic        [15:0] distance,
   input  wire logic               blink_phase,
   input  wire lfpi_pkg::cfg_type  cfg,
   output lfpi_pkg::zone_type      zone,
   output logic                    red_on,
   output logic                    green_on
);

   // limits are tried in fixed order, first strict exceed wins
   always_comb begin
      if (distance > cfg.far_limit) begin
         zone     = lfpi_pkg::ZONE_FAR;
         red_on   = 1'b0;
         green_on = 1'b1;
      end else if (distance > cfg.caution_limit) begin
         zone     = lfpi_pkg::ZONE_CAUTION;
         red_on   = 1'b1;
         green_on = 1'b1;
      end else if (distance > cfg.stop_limit) begin
         zone     = lfpi_pkg::ZONE_NEAR;
         red_on   = 1'b1;
         green_on = 1'b0;
      end else begin
         zone     = lfpi_pkg::ZONE_STOP;
         red_on   = blink_phase;
         green_on = 1'b0;
      end
   end

endmodule

`default_nettype wire

### rtl/lidar_frame_proximity_indicator_top.sv
// flow: a request waits in the input register; once it moves on and ends a
//    frame, its reading loads the result register and rsp_valid rises
// throughput: one request per cycle, bytes and ticks alike, unless the response side stalls;
//    set by the single input register feeding the parser and classifier in one pass
// reset: synchronous, active high; clears both stages, the parser, the blink
//    counter and restores the register defaults
// ----------------------------------------------------------------------------
// lidar_frame_proximity_indicator_top
// lidar byte stream frame parser with distance zone indicator
// ----------------------------------------------------------------------------
`default_nettype none
`include "lidar_frame_proximity_indicator_top_macros.svh"

module lidar_frame_proximity_indicator_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_op,
   input  wire logic [7:0]                  req_byte_value,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [15:0]                 rsp_distance,
   output logic      [1:0]                  rsp_zone,
   output logic                             rsp_red_on,
   output logic                             rsp_green_on,
   // configuration port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [lfpi_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready
);

   // input register stage
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_op_ff;
   logic [7:0]          s1_byte_ff;

   // result register stage
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [15:0]         rsp_distance_ff;
   logic [1:0]          rsp_zone_ff;
   logic                rsp_red_ff;
   logic                rsp_green_ff;

   logic                out_blocked;
   logic                s1_advance;

   lfpi_pkg::cfg_type   cfg;
   lfpi_pkg::frame_type frame;
   lfpi_pkg::zone_type  zone;
   logic                red_on;
   logic                green_on;

   assign pready = 1'b1;

   lfpi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // the result register only blocks when it holds a response not yet taken
   assign out_blocked = rsp_valid_ff & rsp_stall;
   assign s1_advance  = s1_valid_ff & ~out_blocked;
   // the input stage frees up whenever it is empty or can move on
   assign req_stall   = s1_valid_ff & out_blocked;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload captured on every open slot, no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_op_ff   <= req_op;
         s1_byte_ff <= req_byte_value;
      end
   end

   // parser state moves only when the held request moves on
   lfpi_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .step              (s1_advance),
      .op                (s1_op_ff),
      .byte_value        (s1_byte_ff),
      .blink_half_period (cfg.blink_half_period),
      .frame             (frame)
   );

   lfpi_classify u_classify (
      .distance    (frame.distance),
      .blink_phase (frame.blink_phase),
      .cfg         (cfg),
      .zone        (zone),
      .red_on      (red_on),
      .green_on    (green_on)
   );

   // result register: load on a finished frame, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && frame.frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && frame.frame_done) begin
         rsp_distance_ff <= frame.distance;
         rsp_zone_ff     <= zone;
         rsp_red_ff      <= red_on;
         rsp_green_ff    <= green_on;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_zone     = rsp_zone_ff;
   assign rsp_red_on   = rsp_red_ff;
   assign rsp_green_on = rsp_green_ff;

   // a held request is never dropped while the response side is blocked
   `LFPI_ASSERT(a_s1_holds, s1_valid_ff && out_blocked |=> s1_valid_ff, "request lost while blocked")
   // a taken response with nothing new behind it is not shown again
   `LFPI_ASSERT(a_no_repeat, rsp_valid_ff && !rsp_stall && !(s1_advance && frame.frame_done) |=> !rsp_valid_ff, "response repeated")
   // far zone lights green alone
   `LFPI_ASSERT(a_far_green, rsp_valid_ff && rsp_zone_ff == lfpi_pkg::ZONE_FAR |-> rsp_green_ff && !rsp_red_ff, "far zone drive wrong")
   // nothing is held in either stage straight after reset
   `LFPI_ASSERT_ALWAYS(a_reset_clear, reset |=> !s1_valid_ff && !rsp_valid_ff, "stages not cleared by reset")

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lidar frame proximity indicator: a directed
// table of frames and register writes, then randomised phases of frames,
// ticks and noise bytes under random idling, each response checked field by
// field against a table reading or an in-bench frame parser and zone classifier
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int LIMIT_CYCLES   = 400000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_REQUESTS = 210;
   localparam int NUM_PHASES     = 6;
   localparam int CSR_ADDR_W     = lfpi_pkg::ADDR_W;

   // one indicator reading, as the response channel carries it
   typedef struct packed {
      logic [15:0]        distance;
      lfpi_pkg::zone_type zone;
      logic               red_on;
      logic               green_on;
   } reading_type;

   localparam reading_type NO_READING = '{16'd0, lfpi_pkg::ZONE_FAR, 1'b0, 1'b0};

   // directed table rows: either a request or a register write
   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    op;
      logic [7:0]              byte_value;
      lfpi_pkg::reg_index_type idx;
      logic [31:0]             wdata;
      logic                    typed;
      reading_type             want;
   } stim_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // block ports, all driven to known values from time zero
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_op         = lfpi_pkg::OP_BYTE;
   logic [7:0]            req_byte_value = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [15:0]           rsp_distance;
   logic [1:0]            rsp_zone;
   logic                  rsp_red_on;
   logic                  rsp_green_on;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [31:0]           pwdata         = 32'd0;
   logic [31:0]           prdata;
   logic                  pready;

   lidar_frame_proximity_indicator_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_byte_value (req_byte_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_distance   (rsp_distance),
      .rsp_zone       (rsp_zone),
      .rsp_red_on     (rsp_red_on),
      .rsp_green_on   (rsp_green_on),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // bench copy of the block's registers and parser state, at reset values
   lfpi_pkg::cfg_type   cfg = '{lfpi_pkg::FAR_LIMIT_RESET, lfpi_pkg::CAUTION_LIMIT_RESET,
                                lfpi_pkg::STOP_LIMIT_RESET, lfpi_pkg::BLINK_PERIOD_RESET};
   lfpi_pkg::phase_type parse_at       = lfpi_pkg::PH_HUNT1;
   logic [7:0]          low_seen       = 8'd0;
   logic [15:0]         ticks_in_phase = 16'd0;
   logic                blink          = 1'b0;

   // readings still owed by the block, oldest first
   reading_type due_readings[$];

   int fault_count = 0;
   int sent_count  = 0;
   bit calm        = 1'b0;   // no idling on either side when set

   task automatic report_fault(input string msg);
      $display("tb_top: mismatch: %s", msg);
      fault_count++;
   endtask

   task automatic check_field(input string what, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_fault($sformatf("%s got %0h want %0h", what, got, want));
   endtask

   // advance the parser by one request; returns 1 when a frame completes
   function automatic bit parse_and_classify(input logic op, input logic [7:0] b,
                                             output reading_type r);
      logic [15:0] next_ticks;
      logic [15:0] frame_dist;
      r = NO_READING;
      if (op == lfpi_pkg::OP_TICK) begin
         // blink phase flips once the count reaches the half period
         next_ticks = ticks_in_phase + 16'd1;
         if (next_ticks >= cfg.blink_half_period) begin
            ticks_in_phase = 16'd0;
            blink = ~blink;
         end else begin
            ticks_in_phase = next_ticks;
         end
         return 1'b0;
      end
      case (parse_at)
         lfpi_pkg::PH_HUNT1: begin
            if (b == lfpi_pkg::HEADER_BYTE) parse_at = lfpi_pkg::PH_HUNT2;
            else parse_at = lfpi_pkg::PH_HUNT1;
            return 1'b0;
         end
         lfpi_pkg::PH_HUNT2: begin
            // a stray byte is swallowed and the hunt starts over
            if (b == lfpi_pkg::HEADER_BYTE) parse_at = lfpi_pkg::PH_LOW;
            else parse_at = lfpi_pkg::PH_HUNT1;
            return 1'b0;
         end
         lfpi_pkg::PH_LOW: begin
            low_seen = b;
            parse_at = lfpi_pkg::PH_HIGH;
            return 1'b0;
         end
         default: begin
            frame_dist = {b, low_seen};
            parse_at = lfpi_pkg::PH_HUNT1;
            // limits tried in fixed order, first one exceeded wins
            if (frame_dist > cfg.far_limit)
               r = '{frame_dist, lfpi_pkg::ZONE_FAR, 1'b0, 1'b1};
            else if (frame_dist > cfg.caution_limit)
               r = '{frame_dist, lfpi_pkg::ZONE_CAUTION, 1'b1, 1'b1};
            else if (frame_dist > cfg.stop_limit)
               r = '{frame_dist, lfpi_pkg::ZONE_NEAR, 1'b1, 1'b0};
            else
               r = '{frame_dist, lfpi_pkg::ZONE_STOP, blink, 1'b0};
            return 1'b1;
         end
      endcase
   endfunction

   // distances clustered around the current limits, plus the extremes
   function automatic logic [15:0] pick_distance();
      logic [15:0] base;
      case ($urandom_range(0, 7))
         0: base = cfg.far_limit;
         1: base = cfg.caution_limit;
         2: base = cfg.stop_limit;
         3: return 16'h0000;
         4: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
      return base + 16'($urandom_range(0, 2)) - 16'd1;
   endfunction

   function automatic stim_row_type row_req(input logic op, input logic [7:0] b);
      return '{ROW_REQ, op, b, lfpi_pkg::REG_FAR_LIMIT, 32'd0, 1'b0, NO_READING};
   endfunction

   function automatic stim_row_type row_frame_end(input logic [7:0] b,
                                                  input logic [15:0] want_dist,
                                                  input lfpi_pkg::zone_type zone,
                                                  input logic red, input logic green);
      return '{ROW_REQ, lfpi_pkg::OP_BYTE, b, lfpi_pkg::REG_FAR_LIMIT, 32'd0, 1'b1,
               '{want_dist, zone, red, green}};
   endfunction

   function automatic stim_row_type row_csr(input lfpi_pkg::reg_index_type idx,
                                            input logic [31:0] value);
      return '{ROW_CSR, lfpi_pkg::OP_BYTE, 8'd0, idx, value, 1'b0, NO_READING};
   endfunction

   // hand one request over, with an optional idle burst first; the
   // expected reading is booked at the edge that accepts it
   task automatic send_request(input logic op, input logic [7:0] b,
                               input logic typed = 1'b0,
                               input reading_type want = NO_READING);
      reading_type r;
      bit          has;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_byte_value <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has = parse_and_classify(op, b, r);
      if (has) due_readings.push_back(typed ? want : r);
      sent_count++;
   endtask

   // stop sending and let every owed reading come out, then wait out the settle
   // time so ticks still in flight have landed
   task automatic settle();
      req_valid <= 1'b0;
      while (due_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup and access cycles for the write, then a read back of the low half
   task automatic write_reg(input lfpi_pkg::reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         lfpi_pkg::REG_FAR_LIMIT:     cfg.far_limit = value[15:0];
         lfpi_pkg::REG_CAUTION_LIMIT: cfg.caution_limit = value[15:0];
         lfpi_pkg::REG_STOP_LIMIT:    cfg.stop_limit = value[15:0];
         default:                     cfg.blink_half_period = value[15:0];
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== value[15:0])
         report_fault($sformatf("register %s read %0h want %0h", idx.name(),
                                prdata[15:0], value[15:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // response side: random stall bursts, none in the calm part
   initial begin : rsp_idling
      int n;
      forever begin
         n = $urandom_range(1, 17);
         if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat (n + $urandom_range(0, 20)) @(posedge clock);
         end
      end
   end

   // every accepted response against the oldest owed reading
   always @(posedge clock) begin : watch_responses
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_readings.size() == 0) begin
            report_fault($sformatf("response %0h with none outstanding", rsp_distance));
         end else begin
            want = due_readings.pop_front();
            check_field("distance", rsp_distance, want.distance);
            check_field("zone", {14'd0, rsp_zone}, {14'd0, want.zone});
            check_field("red_on", {15'd0, rsp_red_on}, {15'd0, want.red_on});
            check_field("green_on", {15'd0, rsp_green_on}, {15'd0, want.green_on});
         end
      end
   end

   // watchdog on the whole run
   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      stim_row_type dir_tab[$];
      int           start;
      int           burst;
      logic [15:0]  d;
      logic [15:0]  f;
      logic [15:0]  c;
      logic [15:0]  s;
      logic [15:0]  per;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, register defaults: far 200, caution 100, stop 60
      // nearest possible reading, blink phase still low
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, 8'h00));
      dir_tab.push_back(row_frame_end(8'h00, 16'd0, lfpi_pkg::ZONE_STOP, 1'b0, 1'b0));
      // farthest possible reading
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, 8'hFF));
      dir_tab.push_back(row_frame_end(8'hFF, 16'hFFFF, lfpi_pkg::ZONE_FAR, 1'b0, 1'b1));
      // exactly on the far limit is not beyond it
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, 8'hC8));
      dir_tab.push_back(row_frame_end(8'h00, 16'd200, lfpi_pkg::ZONE_CAUTION, 1'b1, 1'b1));
      // broken header: the stray byte restarts the hunt
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, 8'h12));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, 8'h3D));
      dir_tab.push_back(row_frame_end(8'h00, 16'd61, lfpi_pkg::ZONE_NEAR, 1'b1, 1'b0));
      // header-valued distance bytes are data, not a new header
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_frame_end(lfpi_pkg::HEADER_BYTE, 16'h5959, lfpi_pkg::ZONE_FAR,
                                      1'b0, 1'b1));
      // wide write whose low half is zero: blink flips on every tick
      dir_tab.push_back(row_csr(lfpi_pkg::REG_BLINK_HALF_PERIOD, 32'hABCD_0000));
      dir_tab.push_back(row_req(lfpi_pkg::OP_TICK, 8'hFF));
      // on the stop limit, red now lit by the blink phase
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, 8'h3C));
      dir_tab.push_back(row_req(lfpi_pkg::OP_BYTE, 8'h00));

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            settle();
            write_reg(dir_tab[i].idx, dir_tab[i].wdata);
         end else begin
            send_request(dir_tab[i].op, dir_tab[i].byte_value, dir_tab[i].typed,
                         dir_tab[i].want);
         end
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         calm = (ph == NUM_PHASES - 1);
         s = 16'($urandom_range(0, 20000));
         c = s + 16'($urandom_range(0, 20000));
         f = c + 16'($urandom_range(0, 20000));
         case (ph)
            0: begin
               // top limits: nothing is beyond stop, blink every tick
               f = 16'hFFFF; c = 16'hFFFF; s = 16'hFFFF;
               per = 16'd1;
            end
            1: begin
               // zero limits: only a zero distance is in the stop zone
               f = 16'h0000; c = 16'h0000; s = 16'h0000;
               per = 16'd3;
            end
            2: per = 16'($urandom_range(1, 8));
            3: begin
               // limits in any order, longest blink period lets ticks pile up
               f = 16'($urandom()); c = 16'($urandom()); s = 16'($urandom());
               per = 16'hFFFF;
            end
            4: per = 16'($urandom_range(1, 4));   // now below the count held over
            default: begin
               s = 16'($urandom_range(0, 300));
               c = s + 16'($urandom_range(0, 300));
               f = c + 16'($urandom_range(0, 300));
               per = 16'd2;
            end
         endcase
         // upper halves random, the block keeps the low sixteen bits
         write_reg(lfpi_pkg::REG_FAR_LIMIT, {16'($urandom()), f});
         write_reg(lfpi_pkg::REG_CAUTION_LIMIT, {16'($urandom()), c});
         write_reg(lfpi_pkg::REG_STOP_LIMIT, {16'($urandom()), s});
         write_reg(lfpi_pkg::REG_BLINK_HALF_PERIOD, {16'($urandom()), per});

         start = sent_count;
         while (sent_count - start < PHASE_REQUESTS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // well-formed frame with a distance near the limits
                  d = pick_distance();
                  send_request(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE);
                  send_request(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE);
                  send_request(lfpi_pkg::OP_BYTE, d[7:0]);
                  send_request(lfpi_pkg::OP_BYTE, d[15:8]);
               end
               6, 7: begin
                  burst = $urandom_range(1, 6);
                  repeat (burst) send_request(lfpi_pkg::OP_TICK, 8'($urandom()));
               end
               8: send_request(lfpi_pkg::OP_BYTE, 8'($urandom()));
               default: begin
                  // header then anything: mostly a broken frame
                  send_request(lfpi_pkg::OP_BYTE, lfpi_pkg::HEADER_BYTE);
                  send_request(lfpi_pkg::OP_BYTE, 8'($urandom()));
               end
            endcase
            // now and then hold off until the block has caught up
            if (!calm && $urandom_range(0, 59) == 0) settle();
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
